/* hw/rtl/cursor_wall_guard_macros.svh */
// Shared assertion macros for the wall guard.
`ifndef CURSOR_WALL_GUARD_MACROS_SVH
`define CURSOR_WALL_GUARD_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CWG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cwg: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CWG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cwg: next-cycle check failed");

`endif

/* hw/rtl/cwg_pkg.sv */
package cwg_pkg;

	// Operation codes of an input item.
	localparam logic [2:0] OP_FOCUS  = 3'd0;
	localparam logic [2:0] OP_BUTTON = 3'd1;
	localparam logic [2:0] OP_HMOVE  = 3'd2;
	localparam logic [2:0] OP_REPORT = 3'd3;
	localparam logic [2:0] OP_OTHER  = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_WALL_X         = 2'd0;
	localparam logic [1:0] CFG_GRAB_ZONE      = 2'd1;
	localparam logic [1:0] CFG_RELEASE_MARGIN = 2'd2;

	// Mode codes as reported on the result channel.
	localparam logic [1:0] MODE_CODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_CODE_WATCH = 2'd1;
	localparam logic [1:0] MODE_CODE_GUARD = 2'd2;

	localparam int FALLBACK_OFFSET  = 500;
	localparam int UNKNOWN_X        = 9999;
	localparam int BUTTON_MAX       = 255;
	localparam int GRAB_ZONE_RST    = 300;
	localparam int REL_MARGIN_RST   = 200;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_WATCH = 3'b010,
		MODE_GUARD = 3'b100
	} cwg_mode_t;

	typedef struct packed {
		cwg_mode_t   mode;
		logic [7:0]  held;
	} cwg_ctrl_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic               grabbed;
		logic               dropped;
		logic signed [15:0] passed_delta;
		logic signed [15:0] cursor_estimate;
	} cwg_result_t;

	function automatic logic [1:0] mode_code(input cwg_mode_t m);
		logic [1:0] c;
		unique case (m)
			MODE_IDLE:  c = MODE_CODE_IDLE;
			MODE_WATCH: c = MODE_CODE_WATCH;
			MODE_GUARD: c = MODE_CODE_GUARD;
			default:    c = MODE_CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/cwg_in_if.sv */
interface cwg_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic               focus_matched;
	logic               pressed;
	logic signed [15:0] amount;

	modport source (output valid, operation, focus_matched, pressed, amount, input ready);
	modport sink   (input valid, operation, focus_matched, pressed, amount, output ready);
endinterface

/* hw/rtl/cwg_out_if.sv */
interface cwg_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic               grabbed;
	logic               dropped;
	logic signed [15:0] passed_delta;
	logic signed [15:0] cursor_estimate;

	modport source (output valid, mode, grabbed, dropped, passed_delta, cursor_estimate,
		input ready);
	modport sink   (input valid, mode, grabbed, dropped, passed_delta, cursor_estimate,
		output ready);
endinterface

/* hw/rtl/cwg_step.sv */
module cwg_step
	import cwg_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  cwg_ctrl_t                      ctrl,
	input  logic signed [COORD_BITS-1:0]   tracked,
	input  logic signed [15:0]             wall_x,
	input  logic [11:0]                    grab_zone,
	input  logic [11:0]                    release_margin,
	input  logic [2:0]                     operation,
	input  logic                           focus_matched,
	input  logic                           pressed,
	input  logic signed [15:0]             amount,
	output cwg_ctrl_t                      ctrl_nxt,
	output logic signed [COORD_BITS-1:0]   tracked_nxt,
	output cwg_result_t                    result
);

	localparam int CW = (COORD_BITS > 16) ? COORD_BITS : 16;
	localparam int W  = CW + 2;
	localparam logic signed [W-1:0] HI =
		{{(W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [W-1:0] LO = ~HI;
	localparam logic signed [W-1:0] OFFSET_W  = W'(FALLBACK_OFFSET);
	localparam logic signed [W-1:0] UNKNOWN_W = W'(UNKNOWN_X);

	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [W-1:0] v);
		logic signed [COORD_BITS-1:0] r;
		if (v > HI)
			r = HI[COORD_BITS-1:0];
		else if (v < LO)
			r = LO[COORD_BITS-1:0];
		else
			r = v[COORD_BITS-1:0];
		return r;
	endfunction

	logic signed [W-1:0] amt_w, wall_w, trk_w, zone_w, margin_w, space_w, delta_w;
	logic signed [W-1:0] grab_lim_w, rel_lim_w, trk_nxt_w;
	logic                known_op;
	logic                dropped;
	logic signed [15:0]  passed;
	cwg_ctrl_t           c;
	logic signed [COORD_BITS-1:0] t;

	assign amt_w      = W'(amount);
	assign wall_w     = W'(wall_x);
	assign trk_w      = W'(tracked);
	assign zone_w     = W'(grab_zone);
	assign margin_w   = W'(release_margin);
	assign space_w    = trk_w - wall_w;
	assign delta_w    = (amt_w < -space_w) ? -space_w : amt_w;
	assign grab_lim_w = wall_w + zone_w;
	assign rel_lim_w  = grab_lim_w + margin_w;

	always_comb begin
		c        = ctrl;
		t        = tracked;
		dropped  = 1'b0;
		passed   = '0;
		known_op = 1'b1;
		unique case (operation)
			OP_FOCUS: begin
				if (!focus_matched) begin
					c.mode = MODE_IDLE;
				end else if (ctrl.mode == MODE_IDLE) begin
					if (!amount[15])
						t = sat_coord(amt_w);
					else if (!wall_x[15])
						t = sat_coord(wall_w + OFFSET_W);
					else
						t = sat_coord(UNKNOWN_W);
					c.mode = MODE_WATCH;
				end
			end
			OP_BUTTON: begin
				if (ctrl.mode != MODE_IDLE) begin
					if (pressed) begin
						if (ctrl.held != 8'(BUTTON_MAX))
							c.held = ctrl.held + 8'd1;
					end else if (ctrl.held != 8'd0) begin
						c.held = ctrl.held - 8'd1;
					end
				end
			end
			OP_HMOVE: begin
				if (ctrl.mode == MODE_GUARD) begin
					if (amount[15]) begin
						if (trk_w <= wall_w) begin
							dropped = 1'b1;
						end else begin
							// clamp leftward motion to the space left before the wall
							passed = delta_w[15:0];
							t      = sat_coord(trk_w + delta_w);
						end
					end else begin
						passed = amount;
						t      = sat_coord(trk_w + amt_w);
					end
				end
			end
			OP_REPORT: begin
				if (!amount[15]) begin
					if (ctrl.mode == MODE_WATCH && !wall_x[15]) begin
						t = sat_coord(amt_w);
						if (amt_w < grab_lim_w && ctrl.held == 8'd0)
							c.mode = MODE_GUARD;
					end else if (ctrl.mode == MODE_GUARD) begin
						t = sat_coord(amt_w);
					end
				end
			end
			OP_OTHER: begin
			end
			default: begin
				known_op = 1'b0;
			end
		endcase

		trk_nxt_w = W'(t);
		if (c.mode == MODE_GUARD && known_op && trk_nxt_w > rel_lim_w && c.held == 8'd0)
			c.mode = MODE_WATCH;
	end

	assign ctrl_nxt    = c;
	assign tracked_nxt = t;

	assign result.mode            = mode_code(c.mode);
	assign result.grabbed         = (c.mode == MODE_GUARD);
	assign result.dropped         = dropped;
	assign result.passed_delta    = passed;
	assign result.cursor_estimate = trk_nxt_w[15:0];

endmodule

/* hw/rtl/cursor_wall_guard.sv */
// An item that transfers on events is registered in the input stage, then in the result stage,
// where it is valid on results. Throughput: one item per cycle while results is not stalled;
// the guard state loop closes through one short compare/add path.
// Reset (arst_n low, asynchronous): mode idle, no buttons held, tracked x 9999 (saturated to
// COORD_BITS), wall unknown (-1), grab zone 300, release margin 200, both stages empty.
`include "cursor_wall_guard_macros.svh"

module cursor_wall_guard
	import cwg_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_wdata,
	cwg_in_if.sink        events,
	cwg_out_if.source     results
);

	localparam int CoordMax = (1 << (COORD_BITS - 1)) - 1;
	localparam int TrackRst = (UNKNOWN_X > CoordMax) ? CoordMax : UNKNOWN_X;

	// Configuration registers.
	logic signed [15:0] wall_x_q;
	logic [11:0]        grab_zone_q;
	logic [11:0]        release_margin_q;

	// Guard state: mode, held-button count and tracked cursor x.
	cwg_ctrl_t                    ctrl_q;
	logic signed [COORD_BITS-1:0] tracked_q;

	// Input stage.
	logic               valid_s1;
	logic [2:0]         operation_s1;
	logic               matched_s1;
	logic               pressed_s1;
	logic signed [15:0] amount_s1;

	// Result stage.
	logic               valid_s2;
	cwg_result_t        result_s2;

	cwg_ctrl_t                    ctrl_nxt;
	logic signed [COORD_BITS-1:0] tracked_nxt;
	cwg_result_t                  result_nxt;
	logic                         advance;

	// Move the input stage into the result stage whenever the result stage is empty or
	// being drained; the guard state commits on that same edge, so back-to-back items see
	// the state left by their predecessor.
	assign advance      = valid_s1 && (!valid_s2 || results.ready);
	assign events.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_x_q         <= -16'sd1;
			grab_zone_q      <= 12'(GRAB_ZONE_RST);
			release_margin_q <= 12'(REL_MARGIN_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WALL_X:         wall_x_q         <= cfg_wdata;
				CFG_GRAB_ZONE:      grab_zone_q      <= cfg_wdata[11:0];
				CFG_RELEASE_MARGIN: release_margin_q <= cfg_wdata[11:0];
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	// Input stage: hold the item until the result stage can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			operation_s1 <= events.operation;
			matched_s1   <= events.focus_matched;
			pressed_s1   <= events.pressed;
			amount_s1    <= events.amount;
		end
	end

	cwg_step #(
		.COORD_BITS (COORD_BITS)
	) u_step (
		.ctrl           (ctrl_q),
		.tracked        (tracked_q),
		.wall_x         (wall_x_q),
		.grab_zone      (grab_zone_q),
		.release_margin (release_margin_q),
		.operation      (operation_s1),
		.focus_matched  (matched_s1),
		.pressed        (pressed_s1),
		.amount         (amount_s1),
		.ctrl_nxt       (ctrl_nxt),
		.tracked_nxt    (tracked_nxt),
		.result         (result_nxt)
	);

	// Commit guard state only when the item actually advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.mode <= MODE_IDLE;
			ctrl_q.held <= 8'd0;
			tracked_q   <= COORD_BITS'(TrackRst);
		end else if (advance) begin
			ctrl_q    <= ctrl_nxt;
			tracked_q <= tracked_nxt;
		end
	end

	// Result stage: hold a finished result until the consumer takes the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign results.valid           = valid_s2;
	assign results.mode            = result_s2.mode;
	assign results.grabbed         = result_s2.grabbed;
	assign results.dropped         = result_s2.dropped;
	assign results.passed_delta    = result_s2.passed_delta;
	assign results.cursor_estimate = result_s2.cursor_estimate;

	// A dropped motion happens only while guarding and never forwards any delta.
	`CWG_ASSERT_IMPLY(a_drop_guarded, clk, arst_n, results.valid && results.dropped,
		results.grabbed && results.passed_delta == 16'sd0)

	// Guard state moves only on an advancing item.
	`CWG_ASSERT_NEXT(a_state_hold, clk, arst_n, !advance, $stable(ctrl_q) && $stable(tracked_q))

	// Back-pressure on events only when both stages are full and results is stalled.
	`CWG_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !events.ready,
		valid_s1 && valid_s2 && !results.ready)

endmodule
